[hw/rtl/mec_pkg.sv]
// Shared widths, constants, control structs and saturation helper for the escape counter.
package mec_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;

    localparam int PROD_W = 2 * COORD_WIDTH;
    localparam int WIDE_W = 2 * COORD_WIDTH + 2;

    localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(255);

    // |z|^2 bound of 4.0 at the scale of the exact squares
    localparam logic signed [WIDE_W-1:0] ESC_LIMIT =
        {{(WIDE_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] COORD_MAX_W =
        {{(WIDE_W-COORD_WIDTH){1'b0}}, COORD_MAX};
    localparam logic signed [WIDE_W-1:0] COORD_MIN_W =
        {{(WIDE_W-COORD_WIDTH){1'b1}}, COORD_MIN};

    typedef struct packed {
        logic load;   // capture c and seed z = c
        logic mul;    // register the three products
        logic step;   // advance z to z*z + c
    } t_dp_cmd;

    typedef struct packed {
        logic escape; // |z|^2 > 4 for the registered products
    } t_dp_stat;

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [COORD_WIDTH-1:0] r;
        if (v > COORD_MAX_W) begin
            r = COORD_MAX;
        end else if (v < COORD_MIN_W) begin
            r = COORD_MIN;
        end else begin
            r = v[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/mec_datapath.sv]
// Datapath: iterate registers, product registers, escape test and z update.
module mec_datapath import mec_pkg::*; (
    input  logic                          i_clk,
    input  logic signed [COORD_WIDTH-1:0] i_c_real,
    input  logic signed [COORD_WIDTH-1:0] i_c_imag,
    input  t_dp_cmd                       i_cmd,
    output t_dp_stat                      o_stat
);

    logic signed [COORD_WIDTH-1:0] r_cr, r_ci, r_x, r_y;
    logic signed [PROD_W-1:0]      r_xx, r_yy, r_xy;

    logic signed [WIDE_W-1:0] w_xx, w_yy, w_xy, w_sum, w_diff, w_re, w_im, w_nx, w_ny;

    always_comb begin
        w_xx   = {{(WIDE_W-PROD_W){r_xx[PROD_W-1]}}, r_xx};
        w_yy   = {{(WIDE_W-PROD_W){r_yy[PROD_W-1]}}, r_yy};
        w_xy   = {{(WIDE_W-PROD_W){r_xy[PROD_W-1]}}, r_xy};
        w_sum  = w_xx + w_yy;
        w_diff = w_xx - w_yy;
        // floor to FRAC_BITS; the cross term carries the factor of two
        w_re   = w_diff >>> FRAC_BITS;
        w_im   = w_xy >>> (FRAC_BITS - 1);
        w_nx   = w_re + {{(WIDE_W-COORD_WIDTH){r_cr[COORD_WIDTH-1]}}, r_cr};
        w_ny   = w_im + {{(WIDE_W-COORD_WIDTH){r_ci[COORD_WIDTH-1]}}, r_ci};
    end

    assign o_stat.escape = (w_sum > ESC_LIMIT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cr <= i_c_real;
            r_ci <= i_c_imag;
            r_x  <= i_c_real;
            r_y  <= i_c_imag;
        end else if (i_cmd.step) begin
            r_x <= sat_coord(w_nx);
            r_y <= sat_coord(w_ny);
        end
        if (i_cmd.mul) begin
            r_xx <= PROD_W'(r_x) * PROD_W'(r_x);
            r_yy <= PROD_W'(r_y) * PROD_W'(r_y);
            r_xy <= PROD_W'(r_x) * PROD_W'(r_y);
        end
    end

endmodule

[hw/rtl/mec_ctrl.sv]
// Controller: request handshakes, iteration counter, limit register and result register.
module mec_ctrl import mec_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [COUNT_WIDTH-1:0] o_escape_count,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_WIDTH-1:0]   i_cfg_data,
    output t_dp_cmd                o_cmd,
    input  t_dp_stat               i_stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_POST
    } t_state;

    t_state                 r_state;
    logic [COUNT_WIDTH-1:0] r_max;
    logic [COUNT_WIDTH-1:0] r_n;
    logic [COUNT_WIDTH-1:0] r_res;
    logic                   r_out_valid;
    logic [COUNT_WIDTH-1:0] r_out_count;

    logic [COUNT_WIDTH-1:0] n_n;
    logic                   w_slot_free;

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_escape_count = r_out_count;
    assign n_n            = r_n + COUNT_WIDTH'(1);
    assign w_slot_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd.load = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.mul  = (r_state == ST_MUL);
        o_cmd.step = (r_state == ST_CHK) && !i_stat.escape;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_max       <= MAX_ITER_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= COUNT_WIDTH'(i_cfg_data);
            end
            // drop the result once taken; in ST_POST the refill below decides
            if (r_out_valid && !i_out_stall && (r_state != ST_POST)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_n <= '0;
                        if (r_max == '0) begin
                            r_res   <= '0;
                            r_state <= ST_POST;
                        end else begin
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (i_stat.escape) begin
                        r_res   <= r_n;
                        r_state <= ST_POST;
                    end else if (n_n == r_max) begin
                        r_res   <= r_max;
                        r_state <= ST_POST;
                    end else begin
                        r_n     <= n_n;
                        r_state <= ST_MUL;
                    end
                end
                ST_POST: begin
                    // hold until the output register is free
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_count <= r_res;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/mandelbrot_escape_counter_unit.sv]
// Top level of the Mandelbrot escape-time counter: controller plus datapath.
//
//  channel  direction  handshake               payload
//  in       request in i_in_valid / o_in_stall  i_c_real, i_c_imag (signed Q4.28)
//  out      result out o_out_valid / i_out_stall o_escape_count (16 bit)
//  cfg      write in   i_cfg_valid / o_cfg_ready i_cfg_data (max_iterations)
//
// A request escaping at count N reports N, one reaching the limit L reports L: each
// iteration passes through the three 32x32 multipliers and then through the escape
// compare and the saturated z update.
// A limit of zero reports zero. Reset sets max_iterations to 255 and empties the output
// register. A new request is taken while a finished result waits in the output register;
// the finished count of that request waits for the register to drain.
module mandelbrot_escape_counter_unit import mec_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_c_real,
    input  logic signed [COORD_WIDTH-1:0] i_c_imag,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [COUNT_WIDTH-1:0]        o_escape_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_WIDTH-1:0]          i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    mec_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_escape_count (o_escape_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_cmd          (w_cmd),
        .i_stat         (w_stat)
    );

    mec_datapath u_datapath (
        .i_clk    (i_clk),
        .i_c_real (i_c_real),
        .i_c_imag (i_c_imag),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat)
    );

endmodule
